@@ hdl/bxavg_pkg.sv @@
// bxavg_pkg: shared types and fixed widths for the box-average downsampler
// no dependencies; imported by box_average_downsampler
`default_nettype none

package bxavg_pkg;

    // fixed field and register widths
    localparam int PIX_W    = 16;
    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 13;
    localparam int CFG_W    = 13;
    localparam int COL_W    = 11;
    localparam int ROW_W    = 12;
    localparam int LX_W     = 12;
    localparam int PART_W   = 19;
    localparam int SUM_W    = 22;

    // effective register limits
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = WIDTH_W'(2048);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = HEIGHT_W'(4096);
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(512);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(512);

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_HR_WIDTH  = 1'b0,
        REG_HR_HEIGHT = 1'b1
    } bxavg_reg_t;

    // per-pixel position flags carried with a beat into the sum stage
    typedef struct packed {
        logic keep;
        logic dx_first;
        logic dx_last;
        logic dy_first;
        logic dy_last;
        logic eol;
        logic eof;
    } bxavg_flags_t;

endpackage

`default_nettype wire

@@ hdl/bxavg_ram.sv @@
// bxavg_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies; holds the column sums of the downsampler
`default_nettype none

module bxavg_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 1024
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read and write of one address in a cycle returns old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/box_average_downsampler.sv @@
// a result beat passes the input register, the stage 2 sum register and the output register
// throughput: one input beat per cycle, sustained; stalls only when the output is held
// pipeline: input/position register, line-store add and write, reciprocal multiply, output
// reset: position counters and pipeline valids clear, hr_width and hr_height go to 512
// the column-sum line store is not cleared; each entry is written before it is read
// box_average_downsampler: imports bxavg_pkg, instantiates bxavg_ram
`default_nettype none

module box_average_downsampler
    import bxavg_pkg::*;
#(
    parameter int SCALE        = 2,
    parameter int MAX_LR_WIDTH = 1024,
    parameter int PIXEL_BITS   = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration write port
    input  wire logic                cfg_write,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data,
    // input pixel channel
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [PIX_W-1:0]    hr_pixel,
    // output pixel channel
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [PIX_W-1:0]    lr_pixel,
    output logic                     last_in_line,
    output logic                     last_in_frame
);

    // derived sizes
    localparam int ADDR_W  = (MAX_LR_WIDTH > 1) ? $clog2(MAX_LR_WIDTH) : 1;
    localparam int DX_W    = (SCALE > 1) ? $clog2(SCALE) : 1;
    localparam int CMP_W   = HEIGHT_W + 2;
    localparam int BLK_N   = SCALE * SCALE;
    // floor(s / BLK_N) as (s * DIV_MUL) >> DIV_SH, exact for every SUM_W-bit s
    localparam int DIV_SH  = SUM_W + ((BLK_N > 1) ? $clog2(BLK_N) : 0);
    localparam longint unsigned DIV_MUL_L =
        ((longint'(1) << DIV_SH) + longint'(BLK_N) - 1) / longint'(BLK_N);
    localparam int PROD_W  = 2 * SUM_W + 1;
    localparam logic [SUM_W:0]      DIV_MUL  = (SUM_W + 1)'(DIV_MUL_L);
    localparam logic [PIX_W-1:0]    PIX_MASK = PIX_W'((32'd1 << PIXEL_BITS) - 32'd1);
    localparam logic [DX_W-1:0]     DX_LAST  = DX_W'(SCALE - 1);
    localparam logic [CMP_W-1:0]    BLK_ONE  = CMP_W'(SCALE);
    localparam logic [CMP_W-1:0]    BLK_TWO  = CMP_W'(2 * SCALE);
    localparam logic [LX_W:0]       LX_LIMIT = (LX_W + 1)'(MAX_LR_WIDTH);
    localparam logic [LX_W:0]       LX_END   = (LX_W + 1)'(MAX_LR_WIDTH - 1);

    //--------------------------------------------------------------------
    // configuration registers
    //--------------------------------------------------------------------
    logic [WIDTH_W-1:0]  hr_width_reg;
    logic [HEIGHT_W-1:0] hr_height_reg;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hr_width_reg  <= WIDTH_RST;
            hr_height_reg <= HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (bxavg_reg_t'(cfg_index))
                REG_HR_WIDTH:  hr_width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_HR_HEIGHT: hr_height_reg <= cfg_data[HEIGHT_W-1:0];
                default:       hr_width_reg  <= hr_width_reg;
            endcase
        end
    end

    // zero acts as one, too-large values clamp
    always_comb
    begin
        priority if (hr_width_reg == '0)
            w_eff = WIDTH_W'(1);
        else if (hr_width_reg > WIDTH_MAX)
            w_eff = WIDTH_MAX;
        else
            w_eff = hr_width_reg;

        priority if (hr_height_reg == '0)
            h_eff = HEIGHT_W'(1);
        else if (hr_height_reg > HEIGHT_MAX)
            h_eff = HEIGHT_MAX;
        else
            h_eff = hr_height_reg;
    end

    //--------------------------------------------------------------------
    // handshake and stage control
    //--------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;
    logic in_fire;
    logic out_free;
    logic s2_free;
    logic s1_adv;
    logic s1_emit;

    assign out_free = !out_valid_reg || out_ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_adv   = s1_valid_reg && (!s1_emit || s2_free);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    //--------------------------------------------------------------------
    // position counters, advanced per accepted beat and cleared by a register write
    //--------------------------------------------------------------------
    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] colb_reg, colb_next;   // first column of the current block
    logic [DX_W-1:0]  dx_reg, dx_next;
    logic [LX_W-1:0]  lx_reg, lx_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] rowb_reg, rowb_next;   // first row of the current block
    logic [DX_W-1:0]  dy_reg, dy_next;
    logic             col_wrap;
    logic             row_wrap;

    assign col_wrap = ((WIDTH_W + 1)'(col_reg) + (WIDTH_W + 1)'(1)) >= (WIDTH_W + 1)'(w_eff);
    assign row_wrap = ((HEIGHT_W + 1)'(row_reg) + (HEIGHT_W + 1)'(1))
                      >= (HEIGHT_W + 1)'(h_eff);

    always_comb
    begin
        col_next  = col_reg;
        colb_next = colb_reg;
        dx_next   = dx_reg;
        lx_next   = lx_reg;
        row_next  = row_reg;
        rowb_next = rowb_reg;
        dy_next   = dy_reg;
        if (cfg_write)
        begin
            // any register write restarts the frame
            col_next  = '0;
            colb_next = '0;
            dx_next   = '0;
            lx_next   = '0;
            row_next  = '0;
            rowb_next = '0;
            dy_next   = '0;
        end
        else if (in_fire)
        begin
            if (col_wrap)
            begin
                col_next  = '0;
                colb_next = '0;
                dx_next   = '0;
                lx_next   = '0;
                if (row_wrap)
                begin
                    row_next  = '0;
                    rowb_next = '0;
                    dy_next   = '0;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                    if (dy_reg == DX_LAST)
                    begin
                        dy_next   = '0;
                        rowb_next = rowb_reg + ROW_W'(SCALE);
                    end
                    else
                    begin
                        dy_next = dy_reg + DX_W'(1);
                    end
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
                if (dx_reg == DX_LAST)
                begin
                    dx_next   = '0;
                    colb_next = colb_reg + COL_W'(SCALE);
                    lx_next   = lx_reg + LX_W'(1);
                end
                else
                begin
                    dx_next = dx_reg + DX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            colb_reg <= '0;
            dx_reg   <= '0;
            lx_reg   <= '0;
            row_reg  <= '0;
            rowb_reg <= '0;
            dy_reg   <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            colb_reg <= colb_next;
            dx_reg   <= dx_next;
            lx_reg   <= lx_next;
            row_reg  <= row_next;
            rowb_reg <= rowb_next;
            dy_reg   <= dy_next;
        end
    end

    //--------------------------------------------------------------------
    // flags of the current position
    //--------------------------------------------------------------------
    bxavg_flags_t pos_flags;
    logic         col_fits;
    logic         row_fits;
    logic         col_last_blk;
    logic         row_last_blk;
    logic         lx_in_store;

    // a block is whole when its first column plus SCALE stays within the width
    assign col_fits     = (CMP_W'(colb_reg) + BLK_ONE) <= CMP_W'(w_eff);
    assign row_fits     = (CMP_W'(rowb_reg) + BLK_ONE) <= CMP_W'(h_eff);
    assign col_last_blk = (CMP_W'(colb_reg) + BLK_TWO) > CMP_W'(w_eff);
    assign row_last_blk = (CMP_W'(rowb_reg) + BLK_TWO) > CMP_W'(h_eff);
    assign lx_in_store  = (LX_W + 1)'(lx_reg) < LX_LIMIT;

    always_comb
    begin
        pos_flags.keep     = col_fits && row_fits && lx_in_store;
        pos_flags.dx_first = (dx_reg == '0);
        pos_flags.dx_last  = (dx_reg == DX_LAST);
        pos_flags.dy_first = (dy_reg == '0);
        pos_flags.dy_last  = (dy_reg == DX_LAST);
        // last kept column: last whole block or last line-store entry
        pos_flags.eol      = col_last_blk || ((LX_W + 1)'(lx_reg) == LX_END);
        pos_flags.eof      = pos_flags.eol && row_last_blk;
    end

    //--------------------------------------------------------------------
    // line store
    //--------------------------------------------------------------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [SUM_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [SUM_W-1:0]  ram_rdata;

    assign ram_raddr = lx_reg[ADDR_W-1:0];

    bxavg_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_LR_WIDTH)
    ) u_col_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_fire),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    //--------------------------------------------------------------------
    // stage 1: input register, horizontal partial and column sum update
    //--------------------------------------------------------------------
    logic [PIX_W-1:0]  s1_pix_reg;
    bxavg_flags_t      s1_flags_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    // bypass for a write to the same entry in the cycle the read was issued
    logic              fwd_hit_reg;
    logic [SUM_W-1:0]  fwd_data_reg;
    logic [PART_W-1:0] hp_reg, hp_next;
    logic [SUM_W-1:0]  old_sum;
    logic [SUM_W-1:0]  col_sum;

    always_comb
    begin
        if (s1_flags_reg.dx_first)
            hp_next = PART_W'(s1_pix_reg);
        else
            hp_next = hp_reg + PART_W'(s1_pix_reg);

        old_sum = fwd_hit_reg ? fwd_data_reg : ram_rdata;

        if (s1_flags_reg.dy_first)
            col_sum = SUM_W'(hp_next);
        else
            col_sum = old_sum + SUM_W'(hp_next);
    end

    assign s1_emit   = s1_flags_reg.keep && s1_flags_reg.dx_last && s1_flags_reg.dy_last;
    assign ram_we    = s1_adv && s1_flags_reg.keep && s1_flags_reg.dx_last;
    assign ram_waddr = s1_addr_reg;
    assign ram_wdata = col_sum;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            hp_reg       <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s1_adv && s1_flags_reg.keep)
            begin
                hp_reg <= hp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg   <= hr_pixel & PIX_MASK;
            s1_flags_reg <= pos_flags;
            s1_addr_reg  <= ram_raddr;
            fwd_hit_reg  <= ram_we && (ram_waddr == ram_raddr);
            fwd_data_reg <= ram_wdata;
        end
    end

    //--------------------------------------------------------------------
    // stage 2: block sum awaiting the reciprocal multiply
    //--------------------------------------------------------------------
    logic [SUM_W-1:0] s2_sum_reg;
    logic             s2_eol_reg;
    logic             s2_eof_reg;
    logic             s2_adv;
    logic             s1_to_s2;

    assign s2_adv   = s2_valid_reg && out_free;
    assign s1_to_s2 = s1_adv && s1_emit;

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (s1_to_s2)
            s2_valid_next = 1'b1;
        else if (s2_adv)
            s2_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s2_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_to_s2)
        begin
            s2_sum_reg <= col_sum;
            s2_eol_reg <= s1_flags_reg.eol;
            s2_eof_reg <= s1_flags_reg.eof;
        end
    end

    //--------------------------------------------------------------------
    // output register: mean = floor(sum / SCALE^2)
    //--------------------------------------------------------------------
    logic [PROD_W-1:0] mean_prod;
    logic [PIX_W-1:0]  lr_pixel_reg;
    logic              eol_reg;
    logic              eof_reg;

    assign mean_prod = PROD_W'(s2_sum_reg) * PROD_W'(DIV_MUL);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s2_adv)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            lr_pixel_reg <= PIX_W'(mean_prod >> DIV_SH);
            eol_reg      <= s2_eol_reg;
            eof_reg      <= s2_eof_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign lr_pixel      = lr_pixel_reg;
    assign last_in_line  = eol_reg;
    assign last_in_frame = eof_reg;

`ifndef SYNTHESIS
    // frame end always closes a row
    a_eof_has_eol: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!last_in_frame || last_in_line))
        else $error("last_in_frame without last_in_line");

    // line store is written only by a beat leaving stage 1
    a_write_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> s1_valid_reg)
        else $error("line store write with empty stage 1");

    // a held block sum does not change while the output is blocked
    a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !out_free) |=> (s2_valid_reg && $stable(s2_sum_reg)))
        else $error("stage 2 lost or changed while stalled");

    // a register write restarts the frame
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (col_reg == '0 && row_reg == '0 && lx_reg == '0))
        else $error("position not cleared after register write");

    // input is blocked only when a block-ending beat in stage 1 waits on a full stage 2
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s1_emit && s2_valid_reg))
        else $error("input stalled without a full pipeline");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// testbench: self-checking bench for box_average_downsampler
// drives raster pixel streams through frame-size settings and checks every block mean
// depends on bxavg_pkg and box_average_downsampler
`default_nettype none

module testbench;
    import bxavg_pkg::*;

    localparam int SCALE        = 2;
    localparam int MAX_LR_WIDTH = 1024;

    // one low-resolution output beat as the block should produce it
    typedef struct packed {
        logic [PIX_W-1:0] mean;
        logic             eol;
        logic             eof;
    } lr_beat_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // block inputs, all known from time zero
    logic             cfg_write = 1'b0;
    logic [0:0]       cfg_index = REG_HR_WIDTH;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic [PIX_W-1:0] hr_pixel  = '0;
    logic             out_ready = 1'b0;

    // block outputs
    logic             in_ready;
    logic             out_valid;
    logic [PIX_W-1:0] lr_pixel;
    logic             last_in_line;
    logic             last_in_frame;

    // pixel backlog feeding the driver, and the block means still owed by the block
    logic [PIX_W-1:0] pixel_backlog [$];
    lr_beat_t         lr_expected [$];
    int unsigned      pixels_queued = 0;
    int unsigned      pixels_taken  = 0;
    int unsigned      error_count   = 0;

    // long receiver hold-offs are requested by the stimulus and served by the receiver
    int unsigned      hold_requests = 0;
    int unsigned      holds_served  = 0;

    // mirror of the block's frame state
    logic [SUM_W-1:0]    col_sums [MAX_LR_WIDTH];
    logic [PART_W-1:0]   model_partial = '0;
    logic [COL_W-1:0]    model_col     = '0;
    logic [ROW_W-1:0]    model_row     = '0;
    logic [WIDTH_W-1:0]  model_width   = WIDTH_RST;
    logic [HEIGHT_W-1:0] model_height  = HEIGHT_RST;

    box_average_downsampler #(
        .SCALE        (SCALE),
        .MAX_LR_WIDTH (MAX_LR_WIDTH),
        .PIXEL_BITS   (16)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .hr_pixel      (hr_pixel),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .lr_pixel      (lr_pixel),
        .last_in_line  (last_in_line),
        .last_in_frame (last_in_frame)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // zero reads as one, oversize values clamp to the largest frame
    function automatic int unsigned active_width();
        if (model_width == '0)
            return 1;
        return (model_width > WIDTH_MAX) ? WIDTH_MAX : model_width;
    endfunction

    function automatic int unsigned active_height();
        if (model_height == '0)
            return 1;
        return (model_height > HEIGHT_MAX) ? HEIGHT_MAX : model_height;
    endfunction

    // fold one accepted pixel into the frame state; a finished block yields its mean
    function automatic void accumulate_pixel(input logic [PIX_W-1:0] pix);
        int unsigned      w;
        int unsigned      h;
        int unsigned      col;
        int unsigned      row;
        int unsigned      lr_w;
        int unsigned      lr_h;
        int unsigned      lx;
        int unsigned      ly;
        int unsigned      dx;
        int unsigned      dy;
        logic [SUM_W-1:0] block_sum;
        lr_beat_t         beat;
        w    = active_width();
        h    = active_height();
        col  = model_col;
        row  = model_row;
        lr_w = w / SCALE;
        lr_h = h / SCALE;
        if (lr_w > MAX_LR_WIDTH)
            lr_w = MAX_LR_WIDTH;
        lx = col / SCALE;
        dx = col % SCALE;
        ly = row / SCALE;
        dy = row % SCALE;

        // pixels of trailing partial blocks fall through without touching the sums
        if (lx < lr_w && ly < lr_h)
        begin
            if (dx == 0)
                model_partial = PART_W'(pix);
            else
                model_partial = model_partial + pix;

            if (dx == SCALE - 1)
            begin
                // top row of the block writes the line-store entry, lower rows add to it
                if (dy == 0)
                    block_sum = SUM_W'(model_partial);
                else
                    block_sum = col_sums[lx] + model_partial;
                col_sums[lx] = block_sum;

                if (dy == SCALE - 1)
                begin
                    beat.mean = PIX_W'(block_sum / (SCALE * SCALE));
                    beat.eol  = (lx == lr_w - 1);
                    beat.eof  = beat.eol && (ly == lr_h - 1);
                    lr_expected.push_back(beat);
                end
            end
        end

        // raster advance, wrapping into the next frame after the last pixel
        if (col + 1 >= w)
        begin
            model_col = '0;
            model_row = (row + 1 >= h) ? '0 : ROW_W'(row + 1);
        end
        else
        begin
            model_col = COL_W'(col + 1);
        end
    endfunction

    function automatic void flag_mismatch(input string field, input int unsigned want,
                                          input int unsigned got);
        error_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    // input driver: bursts of random length, random gaps between them
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            hr_pixel   <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            // beat accepted at this edge goes into the prediction
            if (in_valid && in_ready)
            begin
                accumulate_pixel(hr_pixel);
                pixels_taken++;
            end
            // a pending beat holds its payload until taken
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0 || pixel_backlog.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    hr_pixel <= pixel_backlog.pop_front();
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
            end
        end
    end

    // receiver: stalls at a randomly redrawn stall rate, with long hold-offs on request
    int unsigned stall_pct  = 0;
    int unsigned stall_tick = 0;
    int unsigned hold_left  = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            stall_tick++;
            if (stall_tick % 64 == 0)
            begin
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 25;
                    3:       stall_pct = 60;
                    default: stall_pct = 85;
                endcase
            end
            if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // output monitor: every accepted beat against the oldest expected block mean
    always @(posedge clk)
    begin
        lr_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (lr_expected.size() == 0)
            begin
                error_count++;
                $display("%0t: lr_pixel %0h arrived with nothing expected, %s %0b %0b",
                         $time, lr_pixel, "actual eol and eof", last_in_line,
                         last_in_frame);
            end
            else
            begin
                want = lr_expected.pop_front();
                if (lr_pixel !== want.mean)
                    flag_mismatch("lr_pixel", want.mean, lr_pixel);
                if (last_in_line !== want.eol)
                    flag_mismatch("last_in_line", want.eol, last_in_line);
                if (last_in_frame !== want.eof)
                    flag_mismatch("last_in_frame", want.eof, last_in_frame);
            end
        end
    end

    // register write while idle; any write restarts the frame
    task automatic write_frame_size(input bxavg_reg_t which, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (which == REG_HR_WIDTH)
            model_width = value[WIDTH_W-1:0];
        else
            model_height = value[HEIGHT_W-1:0];
        model_partial = '0;
        model_col     = '0;
        model_row     = '0;
    endtask

    task automatic queue_pixel(input logic [PIX_W-1:0] value);
        pixel_backlog.push_back(value);
        pixels_queued++;
    endtask

    // harsh content leans on all-zero and full-scale pixels to hit the sum extremes
    task automatic queue_random_pixels(input int unsigned count, input bit harsh);
        logic [PIX_W-1:0] value;
        for (int unsigned i = 0; i < count; i++)
        begin
            value = PIX_W'($urandom_range(0, 65535));
            if (harsh)
            begin
                case ($urandom_range(0, 3))
                    0:       value = '0;
                    1:       value = '1;
                    default: ;
                endcase
            end
            queue_pixel(value);
        end
    endtask

    // wait for every pixel to be taken and every mean to come out, then let the pipe drain
    task automatic settle();
        int unsigned waited;
        waited = 0;
        while (pixels_taken != pixels_queued)
            @(posedge clk);
        while (lr_expected.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (lr_expected.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d expected block means never arrived, first expected %0h",
                     $time, lr_expected.size(), lr_expected[0].mean);
            lr_expected.delete();
        end
        repeat (8) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int unsigned      random_end;
        int unsigned      frame_pixels;
        int unsigned      count;
        logic [CFG_W-1:0] w_value;
        logic [CFG_W-1:0] h_value;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 4x4 frame: zero block, full-scale block, truncated mean, mixed bit patterns
        // a long output hold-off here backs up the pipeline and stalls the input
        hold_requests++;
        write_frame_size(REG_HR_WIDTH, 13'd4);
        write_frame_size(REG_HR_HEIGHT, 13'd4);
        queue_pixel(16'h0000); queue_pixel(16'h0000); queue_pixel(16'hFFFF); queue_pixel(16'hFFFF);
        queue_pixel(16'h0000); queue_pixel(16'h0000); queue_pixel(16'hFFFF); queue_pixel(16'hFFFF);
        queue_pixel(16'h0001); queue_pixel(16'h0001); queue_pixel(16'hAAAA); queue_pixel(16'h5555);
        queue_pixel(16'h0001); queue_pixel(16'h0000); queue_pixel(16'h5555); queue_pixel(16'hAAAA);
        settle();

        // 3x3 frame: last column and last row are partial blocks and get dropped
        write_frame_size(REG_HR_WIDTH, 13'd3);
        write_frame_size(REG_HR_HEIGHT, 13'd3);
        queue_pixel(16'h8000); queue_pixel(16'h7FFF); queue_pixel(16'hFFFF);
        queue_pixel(16'h0001); queue_pixel(16'h0002); queue_pixel(16'hFFFF);
        queue_pixel(16'hFFFF); queue_pixel(16'hFFFF); queue_pixel(16'hFFFF);
        settle();

        // random frame sizes, mostly whole frames, some cut off mid-frame
        random_end = pixels_queued + 375;
        hold_requests++;
        while (pixels_queued < random_end)
        begin
            case ($urandom_range(0, 9))
                0:       w_value = 13'd0;
                1:       w_value = 13'd1;
                2:       w_value = CFG_W'($urandom_range(1, 15));
                default: w_value = CFG_W'(2 * $urandom_range(1, 8));
            endcase
            // bit 12 lies outside the width register and must be ignored
            if ($urandom_range(0, 7) == 0)
                w_value[12] = 1'b1;
            case ($urandom_range(0, 9))
                0:       h_value = 13'd0;
                1:       h_value = 13'd1;
                2:       h_value = CFG_W'($urandom_range(1, 11));
                default: h_value = CFG_W'(2 * $urandom_range(1, 5));
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                write_frame_size(REG_HR_WIDTH, w_value);
                write_frame_size(REG_HR_HEIGHT, h_value);
            end
            else
            begin
                write_frame_size(REG_HR_HEIGHT, h_value);
                write_frame_size(REG_HR_WIDTH, w_value);
            end
            frame_pixels = active_width() * active_height();
            count        = frame_pixels * $urandom_range(1, 3);
            if ($urandom_range(0, 5) == 0)
                count = $urandom_range(0, count);
            // keep the total pixel count near its target
            if (count > random_end - pixels_queued)
                count = random_end - pixels_queued;
            queue_random_pixels(count, $urandom_range(0, 1));
            settle();
        end

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // overall limit, far above the slowest correct run
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
